// ----- hdl/rrts_pkg.sv -----
// Package for the round-robin task scheduler: status codes, command modes,
// result codes and the command and result payload structs. No dependencies.
`default_nettype none
package rrts_pkg;

  typedef enum logic [2:0] {
    ST_UNUSED = 3'd0,
    ST_INIT   = 3'd1,
    ST_READY  = 3'd2,
    ST_WAIT   = 3'd3,
    ST_SLEEP  = 3'd4,
    ST_DONE   = 3'd5
  } task_status_t;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_START  = 3'd1,
    MODE_SLEEP  = 3'd2,
    MODE_WAIT   = 3'd3,
    MODE_WAKEUP = 3'd4,
    MODE_TICK   = 3'd5,
    MODE_YIELD  = 3'd6,
    MODE_EXIT   = 3'd7
  } mode_t;

  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_FULL    = 2'd1;
  localparam logic [1:0] RC_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  task_id;
    logic [31:0] sleep_ticks;
  } cmd_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       switched;
    logic [3:0] new_task_id;
    logic [1:0] result_code;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hdl/rrts_front.sv -----
// Front end of the scheduler: accepts commands into a two-entry queue.
// Depends on rrts_pkg.
`default_nettype none
module rrts_front
  import rrts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      avail,
  output cmd_t      head
);

  cmd_t       q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign avail = cnt_r != 2'd0;
  assign head  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wr_r <= ~wr_r;
      if (pop && avail) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && avail};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) q_r[wr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ----- hdl/rrts_back.sv -----
// Back end of the scheduler: executes one command at a time, walking the
// slot table one slot per cycle for tick and reschedule. Depends on rrts_pkg.
`default_nettype none
module rrts_back
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic avail,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  output rsp_t      out_rsp
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int FW = $clog2(MAX_TASKS + 1);
  localparam int IW = (SW + 1 > 4) ? SW + 1 : 4;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TICK  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } st_t;

  st_t                st_r, st_nxt;
  task_status_t       status_r [MAX_TASKS];
  logic [31:0]        count_r  [MAX_TASKS];
  logic [SW-1:0]      run_r, before_r, idx_r;
  logic [SW:0]        scan_r;
  logic [FW-1:0]      free_r;
  logic [3:0]         newid_r;
  logic [1:0]         code_r;
  logic [IW-1:0]      tid;
  logic               known;
  logic [31:0]        dec;

  assign tid   = IW'(head.task_id);
  assign known = (tid < IW'(free_r)) && (tid < IW'(MAX_TASKS));
  assign pop   = st_r == S_IDLE && avail;
  assign dec   = count_r[idx_r] - 32'd1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (avail) begin
        case (mode_t'(head.mode))
          MODE_TICK:  st_nxt = S_TICK;
          MODE_SLEEP, MODE_WAIT, MODE_YIELD, MODE_EXIT: st_nxt = S_SCAN;
          default:    st_nxt = S_DONE;
        endcase
      end
      S_TICK: if (idx_r == SW'(MAX_TASKS - 1)) st_nxt = S_SCAN;
      S_SCAN: if (scan_r >= (SW + 1)'(MAX_TASKS) || status_r[scan_r[SW-1:0]] == ST_READY)
        st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      run_r  <= '0;
      free_r <= FW'(1);
      for (int i = 0; i < MAX_TASKS; i++) begin
        status_r[i] <= (i == 0) ? ST_READY : ST_UNUSED;
        count_r[i]  <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (avail) begin
          before_r <= run_r;
          scan_r   <= {1'b0, run_r} + (SW + 1)'(1);
          idx_r    <= '0;
          newid_r  <= '0;
          code_r   <= RC_OK;
          case (mode_t'(head.mode))
            MODE_CREATE: begin
              if (free_r < FW'(MAX_TASKS)) begin
                newid_r <= 4'(free_r);
                status_r[free_r[SW-1:0]] <= ST_INIT;
                count_r[free_r[SW-1:0]]  <= '0;
                free_r <= free_r + FW'(1);
              end else code_r <= RC_FULL;
            end
            MODE_START: begin
              if (!known) code_r <= RC_UNKNOWN;
              else if (status_r[tid[SW-1:0]] == ST_INIT) status_r[tid[SW-1:0]] <= ST_READY;
            end
            MODE_SLEEP, MODE_WAIT: begin
              count_r[run_r]  <= head.sleep_ticks;
              status_r[run_r] <= (head.mode == MODE_SLEEP) ? ST_SLEEP : ST_WAIT;
            end
            MODE_WAKEUP: begin
              if (!known) code_r <= RC_UNKNOWN;
              else if (status_r[tid[SW-1:0]] == ST_SLEEP || status_r[tid[SW-1:0]] == ST_WAIT) begin
                count_r[tid[SW-1:0]]  <= '0;
                status_r[tid[SW-1:0]] <= ST_READY;
              end
            end
            MODE_EXIT: status_r[run_r] <= ST_DONE;
            default: ;
          endcase
        end
        S_TICK: begin
          if (count_r[idx_r] != 32'd0) count_r[idx_r] <= dec;
          if (status_r[idx_r] == ST_SLEEP && (count_r[idx_r] == 32'd0 || dec == 32'd0))
            status_r[idx_r] <= ST_READY;
          idx_r <= idx_r + SW'(1);
        end
        S_SCAN: begin
          if (scan_r >= (SW + 1)'(MAX_TASKS)) run_r <= '0;
          else if (status_r[scan_r[SW-1:0]] == ST_READY) run_r <= scan_r[SW-1:0];
          scan_r <= scan_r + (SW + 1)'(1);
        end
        S_DONE: begin
          out_valid            <= 1'b1;
          out_rsp.running_task <= 4'(run_r);
          out_rsp.switched     <= run_r != before_r;
          out_rsp.new_task_id  <= newid_r;
          out_rsp.result_code  <= code_r;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !out_valid) else $error("pop not followed by work");
  a_free_rng: assert property (@(posedge clk) disable iff (!rst_n)
    free_r >= FW'(1) && free_r <= FW'(MAX_TASKS)) else $error("free slot out of range");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == S_DONE)) else $error("result without done state");
`endif

endmodule
`default_nettype wire

// ----- hdl/round_robin_task_scheduler.sv -----
// Round-robin task scheduler with sleep and wait: a command queue in front
// and a slot-walking executor behind. An accepted command is registered in the
// queue; the executor takes it while idle. Create, start and wakeup go straight
// to the done state; yield, sleep, wait and exit scan for the next ready slot, and
// tick walks all slots first. One command at a time. Results cannot be stalled.
// Synchronous active-low reset restores slot 0 ready.
`default_nettype none
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  cmd_t      in_cmd,
  output logic      out_valid,
  output rsp_t      out_rsp
);

  logic full, pop, avail;
  cmd_t head;

  assign busy = full;

  rrts_front u_front (
    .clk, .rst_n, .push(start), .push_cmd(in_cmd), .full,
    .pop, .avail, .head
  );

  rrts_back #(.MAX_TASKS(MAX_TASKS)) u_back (
    .clk, .rst_n, .avail, .head, .pop, .out_valid, .out_rsp
  );

endmodule
`default_nettype wire
